// ----- src/mhpq_pkg.sv -----
// Shared types and constants of the max-heap priority queue.
// Used by mhpq_core and max_heap_priority_queue; depends on nothing else.
package mhpq_pkg;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_UP   = 6'b000010,
    ST_LAST = 6'b000100,
    ST_DOWN = 6'b001000,
    ST_FIN  = 6'b010000,
    ST_RESP = 6'b100000
  } state_e;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] top_value;
    logic [7:0]         count;
  } mhpq_res_t;

endpackage

// ----- src/max_heap_priority_queue.sv -----
// Max-heap priority queue top level: request handshake and registered result.
// A flagged request (full or empty) goes straight to the response state; a remove that sifts to a leaf
// passes through the last-entry read, a read, compare and write for each heap level, and the final write.
// One request is in work at a time, so a new request is taken only after the last one's result has
// left the core; a finished result waits in the output register while the next request is worked on.
// Reset clears the entry count; the heap memory is not cleared and needs no clearing pass.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               in_opcode_i,
  input  logic signed [31:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         out_status_o,
  output logic signed [31:0] out_removed_value_o,
  output logic signed [31:0] out_top_value_o,
  output logic [7:0]         out_count_o
);

  logic      busy, start, res_valid, res_ready;
  mhpq_res_t res, out_q;
  logic      out_valid_q, out_valid_d;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign res_ready  = !out_valid_q || !out_stall_i;

  mhpq_core #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .opcode_i   (in_opcode_i),
    .key_i      (DATA_WIDTH'(in_value_i)),
    .busy_o     (busy),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_status_o        = out_q.status;
  assign out_removed_value_o = out_q.removed_value;
  assign out_top_value_o     = out_q.top_value;
  assign out_count_o         = out_q.count;

endmodule

// ----- src/mhpq_mem.sv -----
// Heap storage: synchronous memory with one write port and two registered read ports.
// Stands alone; instantiated by mhpq_core.
module mhpq_mem #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_a_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic             re_b_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_a_i) begin
      rdata_a_o <= mem[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_b_i) begin
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ----- src/mhpq_core.sv -----
// Sift engine of the heap: control sequencer, entry count, root copy and heap memory.
// Depends on mhpq_pkg and mhpq_mem.
module mhpq_core
  import mhpq_pkg::*;
#(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         opcode_i,
  input  logic signed [DATA_WIDTH-1:0] key_i,
  output logic                         busy_o,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output mhpq_res_t                    res_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = CW + 1;
  localparam int AW = $clog2(CAPACITY);

  state_e                       state_q, state_d;
  logic [CW-1:0]                count_q, count_d;
  logic [IW-1:0]                hole_q, hole_d;
  logic signed [DATA_WIDTH-1:0] key_q, key_d;
  logic signed [DATA_WIDTH-1:0] root_q, root_d;
  logic signed [DATA_WIDTH-1:0] removed_q, removed_d;
  status_e                      status_q, status_d;

  logic                  we, re_a, re_b;
  logic [AW-1:0]         waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] wdata, rdata_a, rdata_b;

  logic [IW-1:0]                cnt_ext, n_ins, parent, left_idx, right_idx, big_idx;
  logic [IW-1:0]                lc_big, rc_big;
  logic signed [DATA_WIDTH-1:0] big_val;

  function automatic logic [AW-1:0] to_addr(input logic [IW-1:0] idx);
    logic [IW-1:0] a;
    a = idx - 1'b1;
    return a[AW-1:0];
  endfunction

  mhpq_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(DATA_WIDTH),
    .AW   (AW)
  ) u_mem (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .re_a_i   (re_a),
    .raddr_a_i(raddr_a),
    .rdata_a_o(rdata_a),
    .re_b_i   (re_b),
    .raddr_b_i(raddr_b),
    .rdata_b_o(rdata_b)
  );

  assign cnt_ext   = IW'(count_q);
  assign n_ins     = cnt_ext + 1'b1;
  assign parent    = hole_q >> 1;
  assign left_idx  = hole_q << 1;
  assign right_idx = left_idx | IW'(1);
  assign lc_big    = big_idx << 1;
  assign rc_big    = lc_big | IW'(1);

  always_comb begin
    big_idx = hole_q;
    big_val = key_q;
    if (left_idx <= cnt_ext && $signed(rdata_a) > key_q) begin
      big_idx = left_idx;
      big_val = $signed(rdata_a);
    end
    if (right_idx <= cnt_ext && $signed(rdata_b) > big_val) begin
      big_idx = right_idx;
      big_val = $signed(rdata_b);
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    hole_d    = hole_q;
    key_d     = key_q;
    root_d    = root_q;
    removed_d = removed_q;
    status_d  = status_q;
    we        = 1'b0;
    waddr     = to_addr(hole_q);
    wdata     = key_q;
    re_a      = 1'b0;
    re_b      = 1'b0;
    raddr_a   = to_addr(IW'(2));
    raddr_b   = to_addr(IW'(3));
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          removed_d = '0;
          status_d  = STATUS_OK;
          if (opcode_i == OP_INSERT) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = STATUS_FULL;
              state_d  = ST_RESP;
            end else begin
              key_d   = key_i;
              count_d = count_q + 1'b1;
              hole_d  = n_ins;
              if (n_ins == IW'(1)) begin
                state_d = ST_FIN;
              end else begin
                re_a    = 1'b1;
                raddr_a = to_addr(n_ins >> 1);
                state_d = ST_UP;
              end
            end
          end else begin
            if (count_q == '0) begin
              status_d = STATUS_EMPTY;
              state_d  = ST_RESP;
            end else begin
              removed_d = root_q;
              re_a      = 1'b1;
              raddr_a   = to_addr(cnt_ext);
              state_d   = ST_LAST;
            end
          end
        end
      end
      ST_UP: begin
        if (key_q > $signed(rdata_a)) begin
          we     = 1'b1;
          wdata  = rdata_a;
          hole_d = parent;
          if (parent == IW'(1)) begin
            state_d = ST_FIN;
          end else begin
            re_a    = 1'b1;
            raddr_a = to_addr(parent >> 1);
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_LAST: begin
        key_d   = $signed(rdata_a);
        count_d = count_q - 1'b1;
        hole_d  = IW'(1);
        if (count_q == CW'(1)) begin
          state_d = ST_RESP;
        end else begin
          re_a    = IW'(2) <= cnt_ext - 1'b1;
          re_b    = IW'(3) <= cnt_ext - 1'b1;
          state_d = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (big_idx == hole_q) begin
          state_d = ST_FIN;
        end else begin
          we      = 1'b1;
          wdata   = big_val;
          hole_d  = big_idx;
          re_a    = lc_big <= cnt_ext;
          re_b    = rc_big <= cnt_ext;
          raddr_a = to_addr(lc_big);
          raddr_b = to_addr(rc_big);
          if (hole_q == IW'(1)) begin
            root_d = big_val;
          end
        end
      end
      ST_FIN: begin
        we = 1'b1;
        if (hole_q == IW'(1)) begin
          root_d = key_q;
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q    <= hole_d;
    key_q     <= key_d;
    root_q    <= root_d;
    removed_q <= removed_d;
    status_q  <= status_d;
  end

  assign busy_o              = state_q != ST_IDLE;
  assign res_valid_o         = state_q == ST_RESP;
  assign res_o.status        = status_q;
  assign res_o.removed_value = 32'(removed_q);
  assign res_o.top_value     = (count_q == '0) ? '0 : 32'(root_q);
  assign res_o.count         = 8'(count_q);

  a_no_same_entry_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re_a) |-> waddr != raddr_a)
    else $error("heap memory written and read at the same entry");

  a_no_same_entry_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re_b) |-> waddr != raddr_b)
    else $error("heap memory written and read at the same entry");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_hole_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UP || state_q == ST_DOWN || state_q == ST_FIN) |->
      (hole_q != '0 && hole_q <= cnt_ext))
    else $error("sift position outside the heap");

  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LAST |=> count_q == $past(count_q) - 1'b1)
    else $error("remove did not decrement the count");

endmodule

// ----- tb/max_heap_priority_queue_checker.sv -----
// Checker for the max-heap priority queue: keeps its own heap of keys, predicts each result
// and compares the DUT's results in order. Depends on mhpq_pkg for the opcode, status and
// result types.
module max_heap_priority_queue_checker
  import mhpq_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  logic               req_opcode_i,
  input  logic signed [31:0] req_value_i,
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic [1:0]         res_status_i,
  input  logic signed [31:0] res_removed_value_i,
  input  logic signed [31:0] res_top_value_i,
  input  logic [7:0]         res_count_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 full_hits_o,
  output int                 empty_hits_o
);

  logic signed [31:0] heap_keys [1:CAPACITY];
  int unsigned        heap_size;
  mhpq_res_t          heap_results_q [$];

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic signed [31:0] tmp;
    tmp          = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = tmp;
  endfunction

  function automatic mhpq_res_t apply_heap_op(logic op, logic signed [31:0] key);
    mhpq_res_t   res;
    int unsigned idx;
    int unsigned lchild;
    int unsigned rchild;
    int unsigned larger;
    res        = '0;
    res.status = STATUS_OK;
    if (op == OP_INSERT) begin
      if (heap_size >= CAPACITY) begin
        res.status = STATUS_FULL;
      end else begin
        heap_size++;
        heap_keys[heap_size] = key;
        idx = heap_size;
        while (idx > 1 && heap_keys[idx] > heap_keys[idx / 2]) begin
          swap_keys(idx, idx / 2);
          idx = idx / 2;
        end
      end
    end else if (heap_size == 0) begin
      res.status = STATUS_EMPTY;
    end else begin
      res.removed_value = heap_keys[1];
      heap_keys[1] = heap_keys[heap_size];
      heap_size--;
      idx = 1;
      while (1) begin
        lchild = 2 * idx;
        rchild = lchild + 1;
        larger = idx;
        if (lchild <= heap_size && heap_keys[lchild] > heap_keys[larger]) larger = lchild;
        if (rchild <= heap_size && heap_keys[rchild] > heap_keys[larger]) larger = rchild;
        if (larger == idx) break;
        swap_keys(idx, larger);
        idx = larger;
      end
    end
    if (heap_size > 0) res.top_value = heap_keys[1];
    res.count = heap_size[7:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    mhpq_res_t want;
    if (!rst_ni) begin
      heap_size = 0;
      heap_results_q.delete();
      fail_count_o = 0;
      pending_o = 0;
      checked_o = 0;
      full_hits_o = 0;
      empty_hits_o = 0;
    end else begin
      if (res_valid_i && !res_stall_i) begin
        if (heap_results_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count_o++;
        end else begin
          want = heap_results_q.pop_front();
          checked_o++;
          if (res_status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, res_status_i);
            fail_count_o++;
          end
          if (res_removed_value_i !== want.removed_value) begin
            $error("removed_value: expected %0d, got %0d", want.removed_value,
                   res_removed_value_i);
            fail_count_o++;
          end
          if (res_top_value_i !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, res_top_value_i);
            fail_count_o++;
          end
          if (res_count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, res_count_i);
            fail_count_o++;
          end
        end
      end
      if (req_valid_i && !req_stall_i) begin
        want = apply_heap_op(req_opcode_i, req_value_i);
        if (want.status == STATUS_FULL) full_hits_o++;
        if (want.status == STATUS_EMPTY) empty_hits_o++;
        heap_results_q.push_back(want);
      end
      pending_o = heap_results_q.size();
    end
  end

endmodule

// ----- tb/max_heap_priority_queue_tb.sv -----
// Testbench top for max_heap_priority_queue: drives directed and random insert/remove
// requests under several stall patterns and gives the verdict. Depends on mhpq_pkg, the
// DUT and max_heap_priority_queue_checker.
module max_heap_priority_queue_tb;
  import mhpq_pkg::*;

  localparam int CAPACITY   = 128;
  localparam int IDLE_LIMIT = 5000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               in_opcode_i;
  logic signed [31:0] in_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [1:0]         out_status_o;
  logic signed [31:0] out_removed_value_o;
  logic signed [31:0] out_top_value_o;
  logic [7:0]         out_count_o;

  int fail_count;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int gap_pct;
  int stall_pct;
  int idle_cycles;
  int n_inserts;
  int n_removes;

  max_heap_priority_queue #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .in_opcode_i        (in_opcode_i),
    .in_value_i         (in_value_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_status_o       (out_status_o),
    .out_removed_value_o(out_removed_value_o),
    .out_top_value_o    (out_top_value_o),
    .out_count_o        (out_count_o)
  );

  max_heap_priority_queue_checker #(
    .CAPACITY(CAPACITY)
  ) checker_inst (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .req_valid_i        (in_valid_i),
    .req_stall_i        (in_stall_o),
    .req_opcode_i       (in_opcode_i),
    .req_value_i        (in_value_i),
    .res_valid_i        (out_valid_o),
    .res_stall_i        (out_stall_i),
    .res_status_i       (out_status_o),
    .res_removed_value_i(out_removed_value_o),
    .res_top_value_i    (out_top_value_o),
    .res_count_i        (out_count_o),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .checked_o          (checked),
    .full_hits_o        (full_hits),
    .empty_hits_o       (empty_hits)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("max_heap_priority_queue_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic signed [31:0] pick_key();
    case ($urandom_range(9))
      4, 5, 6: return 32'($urandom_range(16)) - 32'd8;
      7:       return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      8:       return $urandom_range(1) ? 32'h7fffffff - 32'($urandom_range(3))
                                        : 32'h80000000 + 32'($urandom_range(3));
      default: return $urandom();
    endcase
  endfunction

  // Holds the request until the DUT takes it; valid stays high into the next request unless a gap is drawn.
  task automatic send_request(input logic op, input logic signed [31:0] key);
    @(negedge clk_i);
    while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_opcode_i <= op;
    in_value_i  <= key;
    if (op == OP_INSERT) n_inserts++;
    else n_removes++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    in_valid_i  = 1'b0;
    in_opcode_i = OP_INSERT;
    in_value_i  = '0;
    out_stall_i = 1'b0;
    rst_ni      = 1'b0;
    gap_pct     = 0;
    stall_pct   = 0;
    idle_cycles = 0;
    n_inserts   = 0;
    n_removes   = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty remove, extreme keys, equal keys, then drain past empty.
    send_request(OP_REMOVE, 32'sd0);
    send_request(OP_INSERT, 32'sd0);
    send_request(OP_INSERT, 32'h7fffffff);
    send_request(OP_INSERT, 32'h80000000);
    send_request(OP_INSERT, -32'sd1);
    send_request(OP_INSERT, 32'sd1);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'sd5);
    send_request(OP_INSERT, 32'h80000000);
    send_request(OP_REMOVE, 32'hffffffff);
    repeat (9) send_request(OP_REMOVE, $urandom());

    // Each stall pattern aims to fill the heap past capacity, then drain it past empty.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 79; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 79; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        for (int i = 0; i < 175; i++) begin
          if ($urandom_range(99) < (seg == 0 ? 92 : 8)) send_request(OP_INSERT, pick_key());
          else send_request(OP_REMOVE, pick_key());
        end
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests (%0d inserts, %0d removes) under four stall patterns.",
             n_inserts + n_removes, n_inserts, n_removes);
    $display("Checked %0d results; %0d inserts met a full heap, %0d removes an empty one.",
             checked, full_hits, empty_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("max_heap_priority_queue_tb: PASS");
    end else begin
      $display("max_heap_priority_queue_tb: FAIL");
    end
    $finish;
  end

endmodule
